>>> hdl/dkpt_pkg.sv
// Shared types and constants for the digest keyed probe table.
// Slot entry layout, status codes and the memory request bundle.
// No dependencies.
`default_nettype none

package dkpt_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int WORD_W      = 64;
    localparam int DIGEST_W    = 4 * WORD_W;
    localparam int LEN_W       = 32;

    typedef enum logic [2:0] {
        ST_CREATED  = 3'd0,
        ST_FOUND    = 3'd1,
        ST_REPAIRED = 3'd2,
        ST_FULL     = 3'd3,
        ST_GET_HIT  = 3'd4,
        ST_GET_MISS = 3'd5
    } t_status;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_GET   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                valid;
        logic [LEN_W-1:0]    length;
        logic [DIGEST_W-1:0] digest;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

>>> hdl/dkpt_req_if.sv
// Request channel of the probe table: store or get request.
// Depends on nothing.
`default_nettype none

interface dkpt_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;
    logic [31:0] byte_length;
    logic        length_counted;
    logic [9:0]  home_slot;
    logic [9:0]  query_slot;

    modport source (
        output valid, cmd, digest_w0, digest_w1, digest_w2, digest_w3,
               byte_length, length_counted, home_slot, query_slot,
        input  ready
    );
    modport sink (
        input  valid, cmd, digest_w0, digest_w1, digest_w2, digest_w3,
               byte_length, length_counted, home_slot, query_slot,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/dkpt_rsp_if.sv
// Response channel of the probe table: status, slot and stored contents.
// Depends on nothing.
`default_nettype none

interface dkpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  slot_id;
    logic [31:0] out_length;
    logic [63:0] out_digest_w0;
    logic [63:0] out_digest_w1;
    logic [63:0] out_digest_w2;
    logic [63:0] out_digest_w3;

    modport source (
        output valid, status, slot_id, out_length,
               out_digest_w0, out_digest_w1, out_digest_w2, out_digest_w3,
        input  ready
    );
    modport sink (
        input  valid, status, slot_id, out_length,
               out_digest_w0, out_digest_w1, out_digest_w2, out_digest_w3,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/dkpt_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module dkpt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/dkpt_ctrl.sv
// Probe sequencer: clearing pass, linear probe over the slot memory,
// read-modify-write of one entry, and the response register.
// Depends on dkpt_pkg, dkpt_req_if, dkpt_rsp_if.
`default_nettype none

module dkpt_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    dkpt_req_if.sink                    i_req,
    dkpt_rsp_if.source                  o_rsp,
    output dkpt_pkg::t_mem_req          o_mem,
    input  wire dkpt_pkg::t_entry       i_rdata
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    localparam logic [dkpt_pkg::SLOT_W-1:0] LAST_SLOT =
        dkpt_pkg::SLOT_W'(dkpt_pkg::TABLE_SLOTS - 1);
    localparam logic [dkpt_pkg::SLOT_W-1:0] FIRST_SLOT = dkpt_pkg::SLOT_W'(1);

    t_state                                r_state, n_state;
    logic [dkpt_pkg::SLOT_W-1:0]           r_clr_addr, n_clr_addr;
    logic                                  r_cmd, n_cmd;
    logic [dkpt_pkg::DIGEST_W-1:0]         r_digest, n_digest;
    logic [dkpt_pkg::LEN_W-1:0]            r_len, n_len;
    logic                                  r_counted, n_counted;
    logic [dkpt_pkg::SLOT_W-1:0]           r_home, n_home;
    logic [dkpt_pkg::SLOT_W-1:0]           r_slot, n_slot;
    logic [dkpt_pkg::SLOT_W-1:0]           r_query, n_query;

    logic                                  r_out_valid;
    dkpt_pkg::t_status                     r_out_status;
    logic [dkpt_pkg::SLOT_W-1:0]           r_out_slot;
    logic [dkpt_pkg::LEN_W-1:0]            r_out_len;
    logic [dkpt_pkg::DIGEST_W-1:0]         r_out_digest;

    dkpt_pkg::t_status                     res_status;
    logic [dkpt_pkg::SLOT_W-1:0]           res_slot;
    logic [dkpt_pkg::LEN_W-1:0]            res_len;
    logic [dkpt_pkg::DIGEST_W-1:0]         res_digest;

    logic                                  done;
    logic                                  out_free;
    logic                                  out_load;
    logic [dkpt_pkg::SLOT_W-1:0]           start_slot;
    logic [dkpt_pkg::SLOT_W-1:0]           next_slot;
    logic                                  wr_req;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    // slot zero is reserved: a home of zero starts at slot one
    assign start_slot  = (i_req.home_slot == '0) ? FIRST_SLOT : i_req.home_slot;
    assign next_slot   = (r_slot == LAST_SLOT) ? FIRST_SLOT : r_slot + FIRST_SLOT;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cmd      = r_cmd;
        n_digest   = r_digest;
        n_len      = r_len;
        n_counted  = r_counted;
        n_home     = r_home;
        n_slot     = r_slot;
        n_query    = r_query;
        o_mem      = '0;
        done       = 1'b0;
        wr_req     = 1'b0;
        out_load   = 1'b0;
        res_status = dkpt_pkg::ST_GET_MISS;
        res_slot   = '0;
        res_len    = '0;
        res_digest = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + FIRST_SLOT;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd     = i_req.cmd;
                    n_digest  = {i_req.digest_w3, i_req.digest_w2,
                                 i_req.digest_w1, i_req.digest_w0};
                    n_len     = i_req.byte_length;
                    n_counted = i_req.length_counted;
                    n_home    = start_slot;
                    n_slot    = start_slot;
                    n_query   = i_req.query_slot;
                    o_mem.re  = 1'b1;
                    o_mem.raddr = (i_req.cmd == dkpt_pkg::CMD_GET) ?
                                  i_req.query_slot : start_slot;
                    n_state   = S_EVAL;
                end
            end

            S_EVAL: begin
                o_mem.waddr = r_slot;
                if (r_cmd == dkpt_pkg::CMD_GET) begin
                    done = 1'b1;
                    if (r_query != '0 && i_rdata.valid) begin
                        res_status = dkpt_pkg::ST_GET_HIT;
                        res_slot   = r_query;
                        res_len    = i_rdata.length;
                        res_digest = i_rdata.digest;
                    end
                end else if (!i_rdata.valid) begin
                    done              = 1'b1;
                    wr_req            = 1'b1;
                    o_mem.wdata.valid = 1'b1;
                    o_mem.wdata.length = r_len;
                    o_mem.wdata.digest = r_digest;
                    res_status        = dkpt_pkg::ST_CREATED;
                    res_slot          = r_slot;
                end else if (i_rdata.digest == r_digest) begin
                    done       = 1'b1;
                    res_slot   = r_slot;
                    res_status = dkpt_pkg::ST_FOUND;
                    if (r_counted && i_rdata.length != r_len) begin
                        wr_req             = 1'b1;
                        o_mem.wdata.valid  = 1'b1;
                        o_mem.wdata.length = r_len;
                        o_mem.wdata.digest = i_rdata.digest;
                        res_status         = dkpt_pkg::ST_REPAIRED;
                    end
                end else if (next_slot == r_home) begin
                    done       = 1'b1;
                    res_status = dkpt_pkg::ST_FULL;
                end else begin
                    // advance the probe; read data of this slot is dropped
                    o_mem.re    = 1'b1;
                    o_mem.raddr = next_slot;
                    n_slot      = next_slot;
                end

                // hold the read data and skip the write until the response
                // register can take the result
                if (done && out_free) begin
                    out_load = 1'b1;
                    o_mem.we = wr_req;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_digest  <= n_digest;
        r_len     <= n_len;
        r_counted <= n_counted;
        r_home    <= n_home;
        r_slot    <= n_slot;
        r_query   <= n_query;
        if (out_load) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot;
            r_out_len    <= res_len;
            r_out_digest <= res_digest;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slot_id       = r_out_slot;
    assign o_rsp.out_length    = r_out_len;
    assign o_rsp.out_digest_w0 = r_out_digest[0*dkpt_pkg::WORD_W +: dkpt_pkg::WORD_W];
    assign o_rsp.out_digest_w1 = r_out_digest[1*dkpt_pkg::WORD_W +: dkpt_pkg::WORD_W];
    assign o_rsp.out_digest_w2 = r_out_digest[2*dkpt_pkg::WORD_W +: dkpt_pkg::WORD_W];
    assign o_rsp.out_digest_w3 = r_out_digest[3*dkpt_pkg::WORD_W +: dkpt_pkg::WORD_W];

endmodule

`default_nettype wire

>>> hdl/digest_keyed_probe_table_core.sv
// Digest keyed probe table: linear probing insert-or-find over slots 1 to
// 1023 (slot zero is reserved), and get by slot id. A request is accepted
// in the idle state, which issues the first slot read; slots are then probed
// in turn, and a result waits while the response register is full. A new
// request is not taken until the last result is loaded. After reset a
// clearing pass marks every slot free; requests are not taken until it ends.
`default_nettype none

module digest_keyed_probe_table_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dkpt_req_if.sink   i_req,
    dkpt_rsp_if.source o_rsp
);

    dkpt_pkg::t_mem_req mem_req;
    dkpt_pkg::t_entry   mem_rdata;

    dkpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    dkpt_ram #(
        .DEPTH (dkpt_pkg::TABLE_SLOTS),
        .WIDTH (dkpt_pkg::ENTRY_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
